// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, off in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CHK_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("check failed");

`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`else

`define CHK_ALWAYS(label, clk, rst_n, cond)
`define CHK_IMPLY(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/mcps_pkg.sv =====
// ----------------------------------------------------------------------------
// mcps_pkg
// shared constants and types of the minimum capacity partition search
// ----------------------------------------------------------------------------
package mcps_pkg;

	localparam int MAX_ITEMS     = 128;
	localparam int WEIGHT_BITS   = 16;
	localparam int ITEM_WEIGHT_W = 16;
	localparam int CAP_W         = 23;
	localparam int DAYS_CFG_W    = 8;
	localparam int DAYS_W        = DAYS_CFG_W + 1;
	localparam int LOAD_W        = CAP_W + 1;
	localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
	localparam int ADDR_W        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int PDATA_W       = 32;
	localparam int PADDR_W       = 2;

	localparam logic [PADDR_W-1:0] REG_MAX_DAYS = '0;
	localparam logic [DAYS_CFG_W-1:0] MAX_DAYS_RST = DAYS_CFG_W'(1);

	typedef struct packed {
		logic [ITEM_WEIGHT_W-1:0] item_weight;
		logic                     is_last;
	} item_t;

	typedef struct packed {
		logic [CAP_W-1:0] min_capacity;
		logic             overflow;
	} result_t;

	typedef struct packed {
		logic                   en;
		logic [ADDR_W-1:0]      addr;
		logic [WEIGHT_BITS-1:0] data;
	} wr_t;

	typedef struct packed {
		logic             start;
		logic [CAP_W-1:0] cap;
	} probe_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic fits;
	} probe_rsp_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CHECK,
		ST_PROBE,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/mcps_probe.sv =====
// ----------------------------------------------------------------------------
// mcps_probe
// weight memory and greedy feasibility pass for one candidate capacity
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcps_probe (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mcps_pkg::wr_t                    wr,
	input  logic [mcps_pkg::CNT_W-1:0]       count,
	input  logic [mcps_pkg::DAYS_CFG_W-1:0]  max_days,
	input  mcps_pkg::probe_req_t             req,
	output mcps_pkg::probe_rsp_t             rsp
);

	logic [mcps_pkg::WEIGHT_BITS-1:0] mem [mcps_pkg::MAX_ITEMS];

	logic [mcps_pkg::WEIGHT_BITS-1:0] rd_data_s1;
	logic                             rd_vld_s1;
	logic [mcps_pkg::ADDR_W-1:0]      rd_addr;

	logic                          busy_q;
	logic                          fail_q;
	logic [mcps_pkg::CNT_W-1:0]    idx_q;
	logic [mcps_pkg::LOAD_W-1:0]   load_q;
	logic [mcps_pkg::DAYS_W-1:0]   days_q;
	logic [mcps_pkg::CAP_W-1:0]    cap_q;

	logic                          issue;
	logic                          step;
	logic                          done;
	logic [mcps_pkg::LOAD_W-1:0]   load_sum;
	logic                          over;
	logic [mcps_pkg::DAYS_W-1:0]   days_n;
	logic [mcps_pkg::LOAD_W-1:0]   load_n;

	assign rd_addr = idx_q[mcps_pkg::ADDR_W-1:0];

	// single write port during loading, single read port during probing
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_comb begin
		issue    = busy_q && !fail_q && (idx_q < count);
		step     = busy_q && !fail_q && rd_vld_s1;
		done     = busy_q && (fail_q || ((idx_q == count) && !rd_vld_s1));
		load_sum = load_q + mcps_pkg::LOAD_W'(rd_data_s1);
		over     = load_sum > mcps_pkg::LOAD_W'(cap_q);
		days_n   = over ? (days_q + mcps_pkg::DAYS_W'(1)) : days_q;
		load_n   = over ? mcps_pkg::LOAD_W'(rd_data_s1) : load_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			fail_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			idx_q     <= '0;
		end else if (req.start) begin
			busy_q    <= 1'b1;
			fail_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			idx_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + mcps_pkg::CNT_W'(1);
			end
			if (step && (days_n > mcps_pkg::DAYS_W'(max_days))) begin
				fail_q <= 1'b1;
			end
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cap_q  <= req.cap;
			load_q <= '0;
			days_q <= mcps_pkg::DAYS_W'(1);
		end else if (step) begin
			load_q <= load_n;
			days_q <= days_n;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done;
	assign rsp.fits = !fail_q;

	// no memory write while a pass reads the store
	`CHK_IMPLY(a_wr_idle, clk, arst_n, wr.en, !busy_q && !req.start)
	`CHK_IMPLY(a_days_bound, clk, arst_n, busy_q,
		days_q <= (mcps_pkg::DAYS_W'(max_days) + mcps_pkg::DAYS_W'(1)))
	`CHK_NEXT(a_done_ends, clk, arst_n, done && !req.start, !busy_q)

endmodule

// ===== rtl/min_capacity_partition_search.sv =====
// ----------------------------------------------------------------------------
// min_capacity_partition_search
// smallest capacity that ships a weight sequence within max_days
// ----------------------------------------------------------------------------
// Weights load one request per cycle, but only in the load state, into a
// 128-entry memory while the running maximum and sum are kept. The request
// flagged last starts a binary search between them; each probe is one greedy
// pass through the single read port of that memory, and a search takes up to
// ceil(log2(sum - max + 1)) probes, so at most 23. No request is taken during
// the search. The result sits in an output register, so loading of the next
// sequence goes on while it waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module min_capacity_partition_search (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  mcps_pkg::item_t                  item,
	output logic                             result_valid,
	input  logic                             result_ready,
	output mcps_pkg::result_t                result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mcps_pkg::PADDR_W-1:0]     paddr,
	input  logic [mcps_pkg::PDATA_W-1:0]     pwdata,
	output logic [mcps_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	mcps_pkg::state_t state_q;
	mcps_pkg::state_t state_n;

	logic [mcps_pkg::DAYS_CFG_W-1:0]  max_days_q;
	logic [mcps_pkg::CNT_W-1:0]       count_q;
	logic [mcps_pkg::WEIGHT_BITS-1:0] max_q;
	logic [mcps_pkg::CAP_W-1:0]       sum_q;
	logic                             dropped_q;
	logic [mcps_pkg::CAP_W-1:0]       lo_q;
	logic [mcps_pkg::CAP_W-1:0]       hi_q;
	logic [mcps_pkg::CAP_W-1:0]       mid_q;
	logic                             result_valid_q;
	mcps_pkg::result_t                result_q;

	logic                             accept;
	logic                             store;
	logic                             out_load;
	logic                             cfg_wr;
	logic [mcps_pkg::WEIGHT_BITS-1:0] w;
	logic [mcps_pkg::WEIGHT_BITS-1:0] max_n;
	logic [mcps_pkg::CAP_W-1:0]       sum_n;
	logic [mcps_pkg::CAP_W:0]         mid_sum;
	logic [mcps_pkg::CAP_W-1:0]       mid;

	mcps_pkg::wr_t        wr;
	mcps_pkg::probe_req_t req;
	mcps_pkg::probe_rsp_t rsp;

	// configuration port, one register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = mcps_pkg::PDATA_W'(max_days_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_days_q <= mcps_pkg::MAX_DAYS_RST;
		end else if (cfg_wr) begin
			max_days_q <= pwdata[mcps_pkg::DAYS_CFG_W-1:0];
		end
	end

	always_comb begin
		accept  = item_valid && item_ready;
		store   = accept && (count_q < mcps_pkg::CNT_W'(mcps_pkg::MAX_ITEMS));
		w       = item.item_weight[mcps_pkg::WEIGHT_BITS-1:0];
		max_n   = (store && (w > max_q)) ? w : max_q;
		sum_n   = store ? (sum_q + mcps_pkg::CAP_W'(w)) : sum_q;
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[mcps_pkg::CAP_W:1];
	end

	assign wr.en   = store;
	assign wr.addr = count_q[mcps_pkg::ADDR_W-1:0];
	assign wr.data = w;

	// search control
	always_comb begin
		state_n    = state_q;
		item_ready = 1'b0;
		req.start  = 1'b0;
		req.cap    = mid;
		out_load   = 1'b0;
		case (state_q)
			mcps_pkg::ST_LOAD: begin
				item_ready = 1'b1;
				if (item_valid && item.is_last) begin
					state_n = mcps_pkg::ST_CHECK;
				end
			end
			mcps_pkg::ST_CHECK: begin
				if (lo_q < hi_q) begin
					req.start = 1'b1;
					state_n   = mcps_pkg::ST_PROBE;
				end else begin
					state_n = mcps_pkg::ST_OUT;
				end
			end
			mcps_pkg::ST_PROBE: begin
				if (rsp.done) begin
					state_n = mcps_pkg::ST_CHECK;
				end
			end
			mcps_pkg::ST_OUT: begin
				if (!result_valid_q || result_ready) begin
					out_load = 1'b1;
					state_n  = mcps_pkg::ST_LOAD;
				end
			end
			default: begin
				state_n = mcps_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcps_pkg::ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			max_q     <= '0;
			sum_q     <= '0;
			dropped_q <= 1'b0;
		end else if (out_load) begin
			count_q   <= '0;
			max_q     <= '0;
			sum_q     <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			max_q <= max_n;
			sum_q <= sum_n;
			if (store) begin
				count_q <= count_q + mcps_pkg::CNT_W'(1);
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	// search bounds
	always_ff @(posedge clk) begin
		if (accept && item.is_last) begin
			lo_q <= mcps_pkg::CAP_W'(max_n);
			hi_q <= sum_n;
		end else if (req.start) begin
			mid_q <= mid;
		end else if ((state_q == mcps_pkg::ST_PROBE) && rsp.done) begin
			if (rsp.fits) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + mcps_pkg::CAP_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.min_capacity <= lo_q;
			result_q.overflow     <= dropped_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	mcps_probe u_probe (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.count    (count_q),
		.max_days (max_days_q),
		.req      (req),
		.rsp      (rsp)
	);

	`CHK_IMPLY(a_bounds_order, clk, arst_n,
		(state_q == mcps_pkg::ST_CHECK) || (state_q == mcps_pkg::ST_PROBE), lo_q <= hi_q)
	`CHK_ALWAYS(a_count_bound, clk, arst_n,
		count_q <= mcps_pkg::CNT_W'(mcps_pkg::MAX_ITEMS))
	`CHK_IMPLY(a_probe_busy, clk, arst_n, state_q == mcps_pkg::ST_PROBE, rsp.busy)
	`CHK_NEXT(a_last_starts, clk, arst_n, accept && item.is_last,
		(state_q == mcps_pkg::ST_CHECK) && (count_q != '0))

endmodule
